/* rtl/core/rbbs_pkg.sv */
// shared constants, types and helpers for the ring byte buffer with search
package rbbs_pkg;

	localparam int CAPACITY    = 4096;
	localparam int MAX_RUN     = 64;
	localparam int ADDR_W      = $clog2(CAPACITY);
	localparam int FILL_W      = $clog2(CAPACITY + 1);
	localparam int RUN_W       = $clog2(MAX_RUN + 1);
	localparam int BYTE_W      = 8;
	localparam int QUEUE_DEPTH = 2;
	localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

	typedef enum logic [1:0] {
		OP_PUSH    = 2'd0,
		OP_POP     = 2'd1,
		OP_DISCARD = 2'd2,
		OP_SEARCH  = 2'd3
	} op_t;

	typedef enum logic [1:0] {
		ST_OK    = 2'd0,
		ST_FULL  = 2'd1,
		ST_EMPTY = 2'd2
	} status_t;

	typedef enum logic [1:0] {
		BK_IDLE,
		BK_POP,
		BK_SRCH,
		BK_SDONE
	} bk_state_t;

	typedef struct packed {
		op_t               op;
		logic [BYTE_W-1:0] data;
		logic [FILL_W-1:0] count;
		logic [RUN_W-1:0]  run_req;
		logic [ADDR_W-1:0] offset;
		logic [BYTE_W-1:0] key;
	} cmd_t;

	typedef struct packed {
		logic [BYTE_W-1:0] out_byte;
		logic [FILL_W-1:0] done_count;
		logic              found;
		logic [ADDR_W-1:0] position;
		status_t           status;
		logic [FILL_W-1:0] fill_level;
		logic              last;
	} res_t;

	// ring index plus a distance of at most CAPACITY, one compare and subtract
	function automatic logic [ADDR_W-1:0] wrap_add(input logic [ADDR_W-1:0] a,
			input logic [FILL_W-1:0] b);
		logic [FILL_W:0] s;
		s = (FILL_W + 1)'(a) + (FILL_W + 1)'(b);
		if (s >= (FILL_W + 1)'(CAPACITY)) begin
			s = s - (FILL_W + 1)'(CAPACITY);
		end
		return s[ADDR_W-1:0];
	endfunction

endpackage

/* rtl/core/rbbs_front.sv */
// front stage: takes request items and classifies them into commands
module rbbs_front (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        in_valid,
	output logic                        in_ready,
	input  logic [1:0]                  operation,
	input  logic [rbbs_pkg::BYTE_W-1:0] data_byte,
	input  logic [rbbs_pkg::FILL_W-1:0] count,
	input  logic [rbbs_pkg::ADDR_W-1:0] search_offset,
	input  logic [rbbs_pkg::BYTE_W-1:0] search_byte,
	output logic                        cmd_valid,
	output rbbs_pkg::cmd_t              cmd,
	input  logic                        cmd_ready
);
	import rbbs_pkg::*;

	logic valid_s1;
	cmd_t cmd_s1;
	cmd_t cmd_c;

	assign in_ready  = !valid_s1 || cmd_ready;
	assign cmd_valid = valid_s1;
	assign cmd       = cmd_s1;

	// pop requests are capped at the run length here, the fill cap comes later
	always_comb begin
		cmd_c.op     = op_t'(operation);
		cmd_c.data   = data_byte;
		cmd_c.count  = count;
		cmd_c.offset = search_offset;
		cmd_c.key    = search_byte;
		if (count > FILL_W'(MAX_RUN)) begin
			cmd_c.run_req = RUN_W'(MAX_RUN);
		end else begin
			cmd_c.run_req = count[RUN_W-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			cmd_s1 <= cmd_c;
		end
	end

endmodule

/* rtl/core/rbbs_cmd_fifo.sv */
// short command queue between the front stage and the execution unit
module rbbs_cmd_fifo (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           push_valid,
	output logic           push_ready,
	input  rbbs_pkg::cmd_t push_cmd,
	output logic           pop_valid,
	input  logic           pop_ready,
	output rbbs_pkg::cmd_t pop_cmd
);
	import rbbs_pkg::*;

	cmd_t              entry_q [QUEUE_DEPTH];
	logic [QPTR_W-1:0] wr_ptr_q;
	logic [QPTR_W-1:0] rd_ptr_q;
	logic [QPTR_W:0]   cnt_q;
	logic              do_push;
	logic              do_pop;

	assign push_ready = cnt_q != (QPTR_W + 1)'(QUEUE_DEPTH);
	assign pop_valid  = cnt_q != '0;
	assign pop_cmd    = entry_q[rd_ptr_q];
	assign do_push    = push_valid && push_ready;
	assign do_pop     = pop_valid && pop_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			unique case ({do_push, do_pop})
				2'b10:   cnt_q <= cnt_q + 1'b1;
				2'b01:   cnt_q <= cnt_q - 1'b1;
				default: cnt_q <= cnt_q;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (do_push) begin
			entry_q[wr_ptr_q] <= push_cmd;
		end
	end

endmodule

/* rtl/core/rbbs_back.sv */
// execution unit: byte store, head and fill, pop runs, search walk, result register
module rbbs_back (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           cmd_valid,
	output logic           cmd_ready,
	input  rbbs_pkg::cmd_t cmd,
	output logic           out_valid,
	input  logic           out_ready,
	output rbbs_pkg::res_t res
);
	import rbbs_pkg::*;

	logic [BYTE_W-1:0] mem [CAPACITY];
	logic [BYTE_W-1:0] rdata_q;

	bk_state_t         state_q, state_d;
	logic              out_valid_q;
	res_t              res_q;
	logic [ADDR_W-1:0] head_q, head_d;
	logic [FILL_W-1:0] fill_q, fill_d;

	// pop run
	logic [RUN_W-1:0]  run_n_q, run_n_d;
	logic [RUN_W-1:0]  issue_left_q, issue_left_d;
	logic [RUN_W-1:0]  emit_left_q, emit_left_d;
	logic              pend_q, pend_d;

	// search walk
	logic [FILL_W-1:0] issue_idx_q, issue_idx_d;
	logic [ADDR_W-1:0] cmp_idx_q, cmp_idx_d;
	logic              cmp_valid_q, cmp_valid_d;
	logic [BYTE_W-1:0] key_q, key_d;
	logic              sfound_q, sfound_d;
	logic [ADDR_W-1:0] spos_q, spos_d;

	logic              can_load, ld;
	res_t              res_d;
	logic              mem_we, rd_en;
	logic [ADDR_W-1:0] wr_addr, rd_addr;
	logic [RUN_W-1:0]  pop_n;
	logic [FILL_W-1:0] disc_n;
	logic              off_ok, match, more, emit, issue;

	assign can_load  = !out_valid_q || out_ready;
	assign out_valid = out_valid_q;
	assign res       = res_q;

	assign pop_n  = (fill_q < FILL_W'(cmd.run_req)) ? fill_q[RUN_W-1:0] : cmd.run_req;
	assign disc_n = (cmd.count > fill_q) ? fill_q : cmd.count;
	assign off_ok = FILL_W'(cmd.offset) < fill_q;
	assign match  = cmp_valid_q && (rdata_q == key_q);
	assign more   = issue_idx_q < fill_q;
	assign emit   = pend_q && can_load;
	assign issue  = (issue_left_q != '0) && (!pend_q || can_load);

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			BK_IDLE: begin
				if (cmd_valid) begin
					unique case (cmd.op)
						OP_POP: begin
							if (fill_q != '0 && pop_n != '0) begin
								state_d = BK_POP;
							end
						end
						OP_SEARCH: begin
							if (off_ok) begin
								state_d = BK_SRCH;
							end
						end
						OP_PUSH, OP_DISCARD: state_d = BK_IDLE;
					endcase
				end
			end
			BK_POP: begin
				if (emit && emit_left_q == RUN_W'(1)) begin
					state_d = BK_IDLE;
				end
			end
			BK_SRCH: begin
				if (match || !more) begin
					state_d = BK_SDONE;
				end
			end
			BK_SDONE: begin
				if (can_load) begin
					state_d = BK_IDLE;
				end
			end
		endcase
	end

	always_comb begin
		cmd_ready    = 1'b0;
		ld           = 1'b0;
		res_d        = '0;
		res_d.status = ST_OK;
		res_d.last   = 1'b1;
		mem_we       = 1'b0;
		wr_addr      = wrap_add(head_q, fill_q);
		rd_en        = 1'b0;
		rd_addr      = head_q;
		head_d       = head_q;
		fill_d       = fill_q;
		run_n_d      = run_n_q;
		issue_left_d = issue_left_q;
		emit_left_d  = emit_left_q;
		pend_d       = pend_q;
		issue_idx_d  = issue_idx_q;
		cmp_idx_d    = cmp_idx_q;
		cmp_valid_d  = cmp_valid_q;
		key_d        = key_q;
		sfound_d     = sfound_q;
		spos_d       = spos_q;
		unique case (state_q)
			BK_IDLE: begin
				if (cmd_valid) begin
					unique case (cmd.op)
						OP_PUSH: begin
							if (can_load) begin
								cmd_ready = 1'b1;
								ld        = 1'b1;
								if (fill_q == FILL_W'(CAPACITY)) begin
									res_d.status = ST_FULL;
								end else begin
									mem_we           = 1'b1;
									fill_d           = fill_q + 1'b1;
									res_d.done_count = FILL_W'(1);
								end
							end
						end
						OP_POP: begin
							if (fill_q == '0 || pop_n == '0) begin
								if (can_load) begin
									cmd_ready = 1'b1;
									ld        = 1'b1;
									if (fill_q == '0) begin
										res_d.status = ST_EMPTY;
									end
								end
							end else begin
								// fill drops at once: every byte of the run reports the end fill
								cmd_ready    = 1'b1;
								fill_d       = fill_q - FILL_W'(pop_n);
								run_n_d      = pop_n;
								issue_left_d = pop_n;
								emit_left_d  = pop_n;
								pend_d       = 1'b0;
							end
						end
						OP_DISCARD: begin
							if (can_load) begin
								cmd_ready = 1'b1;
								ld        = 1'b1;
								if (fill_q == '0) begin
									res_d.status = ST_EMPTY;
								end else begin
									fill_d           = fill_q - disc_n;
									head_d           = wrap_add(head_q, disc_n);
									res_d.done_count = disc_n;
								end
							end
						end
						OP_SEARCH: begin
							if (off_ok) begin
								cmd_ready   = 1'b1;
								issue_idx_d = FILL_W'(cmd.offset);
								cmp_valid_d = 1'b0;
								key_d       = cmd.key;
							end else if (can_load) begin
								cmd_ready    = 1'b1;
								ld           = 1'b1;
								res_d.status = ST_EMPTY;
							end
						end
					endcase
				end
			end
			BK_POP: begin
				// read data waits in rdata_q until the result register frees up
				if (emit) begin
					ld               = 1'b1;
					res_d.out_byte   = rdata_q;
					res_d.done_count = FILL_W'(run_n_q);
					res_d.last       = emit_left_q == RUN_W'(1);
					emit_left_d      = emit_left_q - 1'b1;
				end
				if (issue) begin
					rd_en        = 1'b1;
					head_d       = wrap_add(head_q, FILL_W'(1));
					issue_left_d = issue_left_q - 1'b1;
				end
				pend_d = issue || (pend_q && !can_load);
			end
			BK_SRCH: begin
				cmp_valid_d = 1'b0;
				if (match) begin
					sfound_d = 1'b1;
					spos_d   = cmp_idx_q;
				end else if (more) begin
					rd_en       = 1'b1;
					rd_addr     = wrap_add(head_q, issue_idx_q);
					cmp_idx_d   = issue_idx_q[ADDR_W-1:0];
					issue_idx_d = issue_idx_q + 1'b1;
					cmp_valid_d = 1'b1;
				end else begin
					sfound_d = 1'b0;
					spos_d   = '0;
				end
			end
			BK_SDONE: begin
				if (can_load) begin
					ld             = 1'b1;
					res_d.found    = sfound_q;
					res_d.position = spos_q;
				end
			end
		endcase
		res_d.fill_level = fill_d;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= BK_IDLE;
			out_valid_q  <= 1'b0;
			head_q       <= '0;
			fill_q       <= '0;
			pend_q       <= 1'b0;
			cmp_valid_q  <= 1'b0;
			issue_left_q <= '0;
			emit_left_q  <= '0;
		end else begin
			state_q      <= state_d;
			head_q       <= head_d;
			fill_q       <= fill_d;
			pend_q       <= pend_d;
			cmp_valid_q  <= cmp_valid_d;
			issue_left_q <= issue_left_d;
			emit_left_q  <= emit_left_d;
			if (ld) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		run_n_q     <= run_n_d;
		issue_idx_q <= issue_idx_d;
		cmp_idx_q   <= cmp_idx_d;
		key_q       <= key_d;
		sfound_q    <= sfound_d;
		spos_q      <= spos_d;
		if (ld) begin
			res_q <= res_d;
		end
	end

	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem[wr_addr] <= cmd.data;
		end
		if (rd_en) begin
			rdata_q <= mem[rd_addr];
		end
	end

endmodule

/* rtl/core/ring_byte_buffer_with_search.sv */
// top level of the ring byte buffer with pop runs, discard and byte search
// A 4096-byte circular FIFO. Each request carries one operation: push one byte,
// pop a run of up to 64 bytes, discard bytes from the head, or search for a byte
// value from an offset past the head. Requests pass a one-stage front register
// and a two-entry command queue, then an execution unit that owns the byte store
// (one write and one registered read port) and a result register, so new
// requests can still be queued while a result waits. Push, discard and every
// request that ends in an error status are answered from the idle state straight
// into the result register. A pop run first takes the request and issues its
// first read, then the single memory read port delivers one byte per cycle while
// the result register is free to take them. A search walks one stored byte per
// cycle through the same read port. Front stage and queue each register a
// request. The store needs no clearing after reset.
module ring_byte_buffer_with_search (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        in_valid,
	output logic                        in_ready,
	input  logic [1:0]                  operation,
	input  logic [rbbs_pkg::BYTE_W-1:0] data_byte,
	input  logic [rbbs_pkg::FILL_W-1:0] count,
	input  logic [rbbs_pkg::ADDR_W-1:0] search_offset,
	input  logic [rbbs_pkg::BYTE_W-1:0] search_byte,
	output logic                        out_valid,
	input  logic                        out_ready,
	output logic [rbbs_pkg::BYTE_W-1:0] out_byte,
	output logic [rbbs_pkg::FILL_W-1:0] done_count,
	output logic                        found,
	output logic [rbbs_pkg::ADDR_W-1:0] position,
	output logic [1:0]                  status,
	output logic [rbbs_pkg::FILL_W-1:0] fill_level,
	output logic                        last
);
	import rbbs_pkg::*;

	logic fr_valid, fr_ready;
	cmd_t fr_cmd;
	logic q_valid, q_ready;
	cmd_t q_cmd;
	res_t res;

	rbbs_front u_front (
		.clk           (clk),
		.arst_n        (arst_n),
		.in_valid      (in_valid),
		.in_ready      (in_ready),
		.operation     (operation),
		.data_byte     (data_byte),
		.count         (count),
		.search_offset (search_offset),
		.search_byte   (search_byte),
		.cmd_valid     (fr_valid),
		.cmd           (fr_cmd),
		.cmd_ready     (fr_ready)
	);

	rbbs_cmd_fifo u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push_valid (fr_valid),
		.push_ready (fr_ready),
		.push_cmd   (fr_cmd),
		.pop_valid  (q_valid),
		.pop_ready  (q_ready),
		.pop_cmd    (q_cmd)
	);

	rbbs_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd_valid (q_valid),
		.cmd_ready (q_ready),
		.cmd       (q_cmd),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.res       (res)
	);

	assign out_byte   = res.out_byte;
	assign done_count = res.done_count;
	assign found      = res.found;
	assign position   = res.position;
	assign status     = res.status;
	assign fill_level = res.fill_level;
	assign last       = res.last;

`ifndef SYNTHESIS
	// a taken byte that is not the end of its run is followed at once by the next
	a_run_continues: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_ready && !last |=> out_valid && done_count == $past(done_count))
		else $error("pop run broken before its last byte");

	a_run_ok: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !last |-> status == ST_OK && done_count != '0)
		else $error("non-final result outside a pop run");

	a_full_push: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && status == ST_FULL |-> done_count == '0 && fill_level == FILL_W'(CAPACITY))
		else $error("full status without a full buffer");

	a_found_ok: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && found |-> status == ST_OK && done_count == '0
			&& FILL_W'(position) < fill_level)
		else $error("search hit outside the stored bytes");
`endif

endmodule

/* test/rbbs_checker.sv */
// response checker for the ring byte buffer: predicts every response and compares it
module rbbs_checker (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        in_valid,
	input  logic                        in_ready,
	input  logic [1:0]                  operation,
	input  logic [rbbs_pkg::BYTE_W-1:0] data_byte,
	input  logic [rbbs_pkg::FILL_W-1:0] count,
	input  logic [rbbs_pkg::ADDR_W-1:0] search_offset,
	input  logic [rbbs_pkg::BYTE_W-1:0] search_byte,
	input  logic                        out_valid,
	input  logic                        out_ready,
	input  logic [rbbs_pkg::BYTE_W-1:0] out_byte,
	input  logic [rbbs_pkg::FILL_W-1:0] done_count,
	input  logic                        found,
	input  logic [rbbs_pkg::ADDR_W-1:0] position,
	input  logic [1:0]                  status,
	input  logic [rbbs_pkg::FILL_W-1:0] fill_level,
	input  logic                        last,
	output int                          mismatches,
	output int                          awaited,
	output int                          checked
);
	timeunit 1ns;
	timeprecision 1ps;

	import rbbs_pkg::*;

	logic [BYTE_W-1:0] ring_bytes [CAPACITY];
	int unsigned       ring_head;
	int unsigned       ring_fill;
	res_t              awaited_responses [$];

	function automatic res_t make_response(input logic [BYTE_W-1:0] value,
			input int unsigned moved, input logic hit, input int unsigned pos,
			input status_t st, input logic final_one);
		res_t r;
		r.out_byte   = value;
		r.done_count = FILL_W'(moved);
		r.found      = hit;
		r.position   = ADDR_W'(pos);
		r.status     = st;
		r.fill_level = FILL_W'(ring_fill);
		r.last       = final_one;
		return r;
	endfunction

	// advances the ring state by one request and queues the responses it causes
	task automatic forecast_responses(input op_t op, input logic [BYTE_W-1:0] value,
			input int unsigned req_count, input int unsigned offset,
			input logic [BYTE_W-1:0] key);
		int unsigned n;
		int unsigned i;
		int unsigned pos;
		logic        hit;
		case (op)
			OP_PUSH: begin
				if (ring_fill >= CAPACITY) begin
					awaited_responses.push_back(make_response(0, 0, 0, 0, ST_FULL, 1));
				end else begin
					ring_bytes[(ring_head + ring_fill) % CAPACITY] = value;
					ring_fill++;
					awaited_responses.push_back(make_response(0, 1, 0, 0, ST_OK, 1));
				end
			end
			OP_POP: begin
				if (ring_fill == 0) begin
					awaited_responses.push_back(make_response(0, 0, 0, 0, ST_EMPTY, 1));
				end else begin
					n = (req_count < ring_fill) ? req_count : ring_fill;
					if (n > MAX_RUN) begin
						n = MAX_RUN;
					end
					if (n == 0) begin
						awaited_responses.push_back(make_response(0, 0, 0, 0, ST_OK, 1));
					end else begin
						// every response of the run reports the fill after the whole run
						ring_fill -= n;
						for (i = 0; i < n; i++) begin
							awaited_responses.push_back(make_response(
								ring_bytes[(ring_head + i) % CAPACITY], n, 0, 0, ST_OK,
								i == n - 1));
						end
						ring_head = (ring_head + n) % CAPACITY;
					end
				end
			end
			OP_DISCARD: begin
				if (ring_fill == 0) begin
					awaited_responses.push_back(make_response(0, 0, 0, 0, ST_EMPTY, 1));
				end else begin
					n = (req_count < ring_fill) ? req_count : ring_fill;
					ring_fill -= n;
					ring_head = (ring_head + n) % CAPACITY;
					awaited_responses.push_back(make_response(0, n, 0, 0, ST_OK, 1));
				end
			end
			default: begin
				if (offset >= ring_fill) begin
					awaited_responses.push_back(make_response(0, 0, 0, 0, ST_EMPTY, 1));
				end else begin
					hit = 1'b0;
					pos = 0;
					for (i = offset; i < ring_fill && !hit; i++) begin
						if (ring_bytes[(ring_head + i) % CAPACITY] == key) begin
							hit = 1'b1;
							pos = i;
						end
					end
					awaited_responses.push_back(make_response(0, 0, hit, pos, ST_OK, 1));
				end
			end
		endcase
	endtask

	always @(posedge clk or negedge arst_n) begin : watch
		res_t seen;
		res_t want;
		if (!arst_n) begin
			ring_head = 0;
			ring_fill = 0;
			awaited_responses.delete();
			mismatches = 0;
			checked = 0;
			awaited = 0;
		end else begin
			if (out_valid && out_ready) begin
				seen.out_byte   = out_byte;
				seen.done_count = done_count;
				seen.found      = found;
				seen.position   = position;
				seen.status     = status_t'(status);
				seen.fill_level = fill_level;
				seen.last       = last;
				checked++;
				if (awaited_responses.size() == 0) begin
					if (mismatches < 10) begin
						$display("%t: response with nothing outstanding: byte %0d done %0d",
							$realtime, seen.out_byte, seen.done_count, " found %0d pos %0d",
							seen.found, seen.position, " status %0d fill %0d last %0d",
							seen.status, seen.fill_level, seen.last);
					end
					mismatches++;
				end else begin
					want = awaited_responses.pop_front();
					if (seen.out_byte !== want.out_byte || seen.done_count !== want.done_count
							|| seen.found !== want.found || seen.position !== want.position
							|| seen.status !== want.status
							|| seen.fill_level !== want.fill_level
							|| seen.last !== want.last) begin
						if (mismatches < 10) begin
							$display("%t: response mismatch", $realtime);
							$display("  expected byte %0d done %0d found %0d pos %0d",
								want.out_byte, want.done_count, want.found, want.position,
								" status %0d fill %0d last %0d",
								want.status, want.fill_level, want.last);
							$display("  actual   byte %0d done %0d found %0d pos %0d",
								seen.out_byte, seen.done_count, seen.found, seen.position,
								" status %0d fill %0d last %0d",
								seen.status, seen.fill_level, seen.last);
						end
						mismatches++;
					end
				end
			end
			if (in_valid && in_ready) begin
				forecast_responses(op_t'(operation), data_byte, count, search_offset,
					search_byte);
			end
			awaited = awaited_responses.size();
		end
	end

endmodule

/* test/ring_byte_buffer_with_search_tb.sv */
// stimulus and verdict for the ring byte buffer with search
module ring_byte_buffer_with_search_tb;
	timeunit 1ns;
	timeprecision 1ps;

	import rbbs_pkg::*;

	// a full-buffer search walks 4096 bytes with no handshake in between
	localparam int STALL_LIMIT  = 20000;
	localparam int DRAIN_CYCLES = 40;

	logic                clk = 1'b0;
	logic                arst_n = 1'b0;
	logic                in_valid = 1'b0;
	logic                in_ready;
	logic [1:0]          operation = OP_PUSH;
	logic [BYTE_W-1:0]   data_byte = '0;
	logic [FILL_W-1:0]   count = '0;
	logic [ADDR_W-1:0]   search_offset = '0;
	logic [BYTE_W-1:0]   search_byte = '0;
	logic                out_valid;
	logic                out_ready = 1'b0;
	logic [BYTE_W-1:0]   out_byte;
	logic [FILL_W-1:0]   done_count;
	logic                found;
	logic [ADDR_W-1:0]   position;
	logic [1:0]          status;
	logic [FILL_W-1:0]   fill_level;
	logic                last;

	int                  mismatches;
	int                  awaited;
	int                  checked;

	int                  sender_idle_pct = 0;
	int                  recv_stall_pct = 0;
	int unsigned         requests_sent = 0;
	// bytes held, tracked to aim searches at stored values and to allow push bursts only below 600 held bytes
	logic [BYTE_W-1:0]   held_bytes [$];

	ring_byte_buffer_with_search dut (.*);

	rbbs_checker chk (.*);

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	always @(negedge clk) begin
		out_ready <= ($urandom_range(99) >= recv_stall_pct);
	end

	task automatic send_request(input op_t op, input logic [BYTE_W-1:0] value,
			input int unsigned req_count, input int unsigned offset,
			input logic [BYTE_W-1:0] key);
		int unsigned       n;
		logic [BYTE_W-1:0] dropped;
		while ($urandom_range(99) < sender_idle_pct) begin
			in_valid = 1'b0;
			@(negedge clk);
		end
		in_valid      = 1'b1;
		operation     = op;
		data_byte     = value;
		count         = FILL_W'(req_count);
		search_offset = ADDR_W'(offset);
		search_byte   = key;
		do @(posedge clk); while (!in_ready);
		@(negedge clk);
		requests_sent++;
		case (op)
			OP_PUSH: begin
				if (held_bytes.size() < CAPACITY) begin
					held_bytes.push_back(value);
				end
			end
			OP_POP, OP_DISCARD: begin
				n = (req_count < held_bytes.size()) ? req_count : held_bytes.size();
				if (op == OP_POP && n > MAX_RUN) begin
					n = MAX_RUN;
				end
				repeat (n) dropped = held_bytes.pop_front();
			end
			default: ;
		endcase
	endtask

	// mostly push bursts, short pops and discards, and searches aimed mostly at stored bytes
	task automatic random_requests(input int unsigned target);
		int unsigned       sent;
		int unsigned       burst;
		int unsigned       fill;
		int unsigned       pick;
		int unsigned       amount;
		int unsigned       off;
		logic [BYTE_W-1:0] key;
		sent = 0;
		while (sent < target) begin
			fill = held_bytes.size();
			pick = $urandom_range(99);
			if (pick < 35 && fill < 600) begin
				burst = $urandom_range(1, 6);
				repeat (burst) begin
					send_request(OP_PUSH, 8'($urandom), $urandom_range(0, CAPACITY),
						$urandom_range(0, CAPACITY - 1), 8'($urandom));
				end
				sent += burst;
			end else if (pick < 60) begin
				amount = ($urandom_range(9) == 0) ? $urandom_range(0, CAPACITY)
					: $urandom_range(0, 10);
				send_request(OP_POP, 8'($urandom), amount,
					$urandom_range(0, CAPACITY - 1), 8'($urandom));
				sent++;
			end else if (pick < 70) begin
				amount = ($urandom_range(9) == 0) ? $urandom_range(0, CAPACITY)
					: $urandom_range(0, 3);
				send_request(OP_DISCARD, 8'($urandom), amount,
					$urandom_range(0, CAPACITY - 1), 8'($urandom));
				sent++;
			end else begin
				if (fill > 0 && $urandom_range(4) != 0) begin
					off = $urandom_range(0, fill - 1);
				end else begin
					off = $urandom_range(0, CAPACITY - 1);
				end
				if (off < fill && $urandom_range(9) < 7) begin
					key = held_bytes[$urandom_range(off, fill - 1)];
				end else begin
					key = 8'($urandom);
				end
				send_request(OP_SEARCH, 8'($urandom), $urandom_range(0, CAPACITY), off, key);
				sent++;
			end
		end
	endtask

	initial begin : watchdog
		int unsigned quiet;
		quiet = 0;
		wait (arst_n === 1'b1);
		while (quiet < STALL_LIMIT) begin
			@(posedge clk);
			if ((in_valid && in_ready) || (out_valid && out_ready)) begin
				quiet = 0;
			end else begin
				quiet++;
			end
		end
		$display("Testbench completed WITH ERRORS");
		$finish;
	end

	initial begin : stimulus
		int unsigned i;
		repeat (7) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// empty buffer refuses pop, discard and search
		send_request(OP_POP, 8'h00, 5, 0, 8'h00);
		send_request(OP_DISCARD, 8'h00, 1, 0, 8'h00);
		send_request(OP_SEARCH, 8'h00, 0, 0, 8'h00);
		send_request(OP_PUSH, 8'h00, 0, 0, 8'h00);
		send_request(OP_PUSH, 8'hFF, 0, 0, 8'h00);
		send_request(OP_PUSH, 8'hA5, 0, 0, 8'h00);
		send_request(OP_POP, 8'h00, 0, 0, 8'h00);
		send_request(OP_SEARCH, 8'h00, 0, 0, 8'hFF);
		// the only zero byte lies before the start offset
		send_request(OP_SEARCH, 8'h00, 0, 1, 8'h00);
		send_request(OP_SEARCH, 8'h00, 0, 0, 8'h5A);
		send_request(OP_SEARCH, 8'h00, 0, 3, 8'hA5);
		send_request(OP_POP, 8'h00, CAPACITY, 0, 8'h00);
		send_request(OP_PUSH, 8'h3C, 0, 0, 8'h00);
		send_request(OP_PUSH, 8'hC3, 0, 0, 8'h00);
		send_request(OP_DISCARD, 8'h00, CAPACITY, 0, 8'h00);

		for (i = 0; i < 4; i++) begin
			case (i)
				0: begin
					sender_idle_pct = 0;
					recv_stall_pct = 0;
				end
				1: begin
					sender_idle_pct = 61;
					recv_stall_pct = 0;
				end
				2: begin
					sender_idle_pct = 0;
					recv_stall_pct = 61;
				end
				default: begin
					sender_idle_pct = 10;
					recv_stall_pct = 10;
				end
			endcase
			random_requests(89);
		end
		in_valid = 1'b0;

		while (awaited != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		$display("%0d requests sent over four idling phases, %0d responses checked",
			requests_sent, checked);
		$display("run covered empty refusals, zero and oversized counts, hits and misses");
		if (mismatches == 0 && awaited == 0) begin
			$display("Testbench completed without errors");
		end else begin
			$display("Testbench completed WITH ERRORS");
		end
		$finish;
	end

endmodule
